FILE: rtl/core/fmb_pkg.sv
// ----------------------------------------------------------------------------
// fmb_pkg
// Shared types and fixed-point helpers for the Fock matrix build unit.
// ----------------------------------------------------------------------------
package fmb_pkg;

    typedef logic signed [63:0] fx_t;

    localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [2:0] {
        MODE_CORE    = 3'd0,
        MODE_INT     = 3'd1,
        MODE_DALPHA  = 3'd2,
        MODE_DBETA   = 3'd3,
        MODE_COMPUTE = 3'd4
    } mode_t;

    localparam logic REG_BASIS = 1'b0;
    localparam logic REG_SPIN  = 1'b1;

    function automatic fx_t sat_add(input fx_t a, input fx_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? FX_MIN : FX_MAX;
        end
        return fx_t'(s[63:0]);
    endfunction

    function automatic fx_t sat_sub(input fx_t a, input fx_t b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? FX_MIN : FX_MAX;
        end
        return fx_t'(s[63:0]);
    endfunction

endpackage

FILE: rtl/core/fmb_ram.sv
// ----------------------------------------------------------------------------
// fmb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fmb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/fmb_fxmul.sv
// ----------------------------------------------------------------------------
// fmb_fxmul
// Multi-cycle signed fixed-point multiplier: four 32x32 partial products,
// round half up, arithmetic shift by FRAC_BITS, saturate to 64 bits.
// ----------------------------------------------------------------------------
module fmb_fxmul #(
    parameter int FRAC_BITS = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  fmb_pkg::fx_t x,
    input  fmb_pkg::fx_t y,
    output logic         done,
    output fmb_pkg::fx_t p
);
    import fmb_pkg::*;

    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_ABS  = 6'b000010,
        M_MUL  = 6'b000100,
        M_NEG  = 6'b001000,
        M_RND  = 6'b010000,
        M_SAT  = 6'b100000
    } mstate_t;

    localparam logic [127:0] RND = 128'(1) << (FRAC_BITS - 1);

    mstate_t      state_reg, state_next;
    logic [2:0]   k_reg, k_next;
    logic         done_reg, done_next;
    fx_t          x_reg, x_next, y_reg, y_next;
    logic [63:0]  ux_reg, ux_next, uy_reg, uy_next;
    logic         neg_reg, neg_next;
    logic [63:0]  prod_reg, prod_next;
    logic [1:0]   sh_reg, sh_next;
    logic [127:0] acc_reg, acc_next;
    fx_t          p_reg, p_next;

    logic [31:0]  xh, yh;
    logic [127:0] shr;
    logic         ovf;

    assign xh  = k_reg[1] ? ux_reg[63:32] : ux_reg[31:0];
    assign yh  = k_reg[0] ? uy_reg[63:32] : uy_reg[31:0];
    assign shr = $signed(acc_reg) >>> FRAC_BITS;
    assign ovf = !((&shr[127:63]) || !(|shr[127:63]));

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        sh_next    = sh_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        unique case (state_reg)
            M_IDLE: begin
                if (start) begin
                    x_next     = x;
                    y_next     = y;
                    state_next = M_ABS;
                end
            end
            M_ABS: begin
                neg_next   = x_reg[63] ^ y_reg[63];
                ux_next    = x_reg[63] ? 64'(-x_reg) : 64'(x_reg);
                uy_next    = y_reg[63] ? 64'(-y_reg) : 64'(y_reg);
                acc_next   = '0;
                k_next     = '0;
                state_next = M_MUL;
            end
            M_MUL: begin
                if (k_reg != 3'd0) begin
                    acc_next = acc_reg + ({64'b0, prod_reg} << {sh_reg, 5'b0});
                end
                if (k_reg == 3'd4) begin
                    state_next = M_NEG;
                end else begin
                    prod_next = xh * yh;
                    sh_next   = 2'({1'b0, k_reg[1]} + {1'b0, k_reg[0]});
                    k_next    = k_reg + 3'd1;
                end
            end
            M_NEG: begin
                acc_next   = neg_reg ? 128'(-acc_reg) : acc_reg;
                state_next = M_RND;
            end
            M_RND: begin
                acc_next   = acc_reg + RND;
                state_next = M_SAT;
            end
            M_SAT: begin
                p_next     = ovf ? (acc_reg[127] ? FX_MIN : FX_MAX) : fx_t'(shr[63:0]);
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        p_reg    <= p_next;
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

FILE: rtl/core/fock_matrix_build_unit.sv
// ----------------------------------------------------------------------------
// fock_matrix_build_unit
// Fock matrix builder over RAM-held core Hamiltonian, densities and ERIs.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the mode, s_tdata the indices and value.
// Load transactions (core, integral, alpha or beta density) are written as
// accepted; an integral load also passes through ST_INT2, as it is written
// at (ij,kl) and (kl,ij). A compute transaction for row m gives N result
// transactions, one per column, m_tlast marking column N-1. Each column
// costs N*N inner steps; a step reads J and K from the single integral RAM
// port, then runs its products through one shared multi-cycle multiplier,
// two products restricted and three unrestricted. s_tready is low for the
// whole row. After reset the integral RAM is cleared, one entry a cycle,
// all P*P entries (278784 with 32 basis functions); no input is taken
// meanwhile, APB writes still are. Results sit in an output register: if
// m_tready is low the next column is computed and then waits for the
// register to free up.
// ----------------------------------------------------------------------------
module fock_matrix_build_unit #(
    parameter int MAX_BASIS = 32,
    parameter int FRAC_BITS = 40
) (
    input  logic          aclk,
    input  logic          aresetn,
    // APB
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [87:0]   s_tdata,  // index_a[9:0], index_b[19:10], value[83:20]
    input  logic [2:0]    s_tuser,  // mode[2:0]
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata,  // row[4:0], col[9:5], fock_alpha[73:10],
                                    // fock_beta[137:74]
    output logic          m_tlast
);
    import fmb_pkg::*;

    localparam int NP = MAX_BASIS * (MAX_BASIS + 1) / 2;
    localparam int BW = $clog2(MAX_BASIS);
    localparam int NW = $clog2(MAX_BASIS + 1);
    localparam int PW = $clog2(NP);
    localparam int DW = $clog2(MAX_BASIS * MAX_BASIS);
    localparam int IW = $clog2(NP * NP);

    typedef enum logic [14:0] {
        ST_CLEAR = 15'h0001,
        ST_IDLE  = 15'h0002,
        ST_INT2  = 15'h0004,
        ST_COL   = 15'h0008,
        ST_COLW  = 15'h0010,
        ST_RDJ   = 15'h0020,
        ST_RDK   = 15'h0040,
        ST_DT    = 15'h0080,
        ST_MJ    = 15'h0100,
        ST_MKA   = 15'h0200,
        ST_MKB   = 15'h0400,
        ST_ACC1  = 15'h0800,
        ST_ACC2  = 15'h1000,
        ST_ACC3  = 15'h2000,
        ST_EMIT  = 15'h4000
    } state_t;

    function automatic logic [PW-1:0] pair_of(input logic [BW-1:0] p, input logic [BW-1:0] q);
        logic [BW-1:0] hi, lo;
        logic [2*BW:0] t;
        hi = (p > q) ? p : q;
        lo = (p > q) ? q : p;
        t  = {{(BW+1){1'b0}}, hi} * ({{(BW+1){1'b0}}, hi} + 1'b1);
        return PW'(t >> 1) + PW'(lo);
    endfunction

    state_t        state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [5:0]    basis_reg, basis_next;
    logic          spin_reg, spin_next;
    logic [BW-1:0] m_reg, m_next, n_reg, n_next, a_reg, a_next, b_reg, b_next;
    logic          ov_reg, ov_next;
    fx_t           fa_reg, fa_next, fb_reg, fb_next;
    fx_t           da_reg, da_next, db_reg, db_next;
    fx_t           jv_reg, jv_next, kv_reg, kv_next;
    fx_t           pj_reg, pj_next, pka_reg, pka_next, pkb_reg, pkb_next;
    logic [IW-1:0] i2a_reg, i2a_next;
    fx_t           i2d_reg, i2d_next;
    logic [4:0]    orow_reg, orow_next, ocol_reg, ocol_next;
    fx_t           ofa_reg, ofa_next, ofb_reg, ofb_next;
    logic          olast_reg, olast_next;

    logic [9:0]    in_ia, in_ib;
    fx_t           in_val;
    logic [2:0]    in_mode;
    logic          s_acc, cfg_wr;
    logic [NW-1:0] neff;
    logic [BW-1:0] nlast;
    logic          mat_ok, int_ok;
    logic [DW-1:0] ld_addr, h_addr, d_addr;
    logic [IW-1:0] ld_iab, ld_iba, j_addr, k_addr;
    logic [PW-1:0] p_ab, p_mn, p_an, p_mb;

    logic          core_we, da_we, db_we, int_we;
    logic [DW-1:0] dens_raddr;
    logic [IW-1:0] int_waddr, int_raddr;
    logic [63:0]   int_wdata, core_q, da_q, db_q, int_q;

    logic          mul_start, mul_done;
    fx_t           mul_x, mul_y, mul_p, dt;

    assign in_ia   = s_tdata[9:0];
    assign in_ib   = s_tdata[19:10];
    assign in_val  = fx_t'(s_tdata[83:20]);
    assign in_mode = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc   = s_tvalid && s_tready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_SPIN) ? {31'b0, spin_reg} : {26'b0, basis_reg};

    always_comb begin
        if (basis_reg == 6'd0) begin
            neff = NW'(1);
        end else if (32'(basis_reg) > MAX_BASIS) begin
            neff = NW'(MAX_BASIS);
        end else begin
            neff = NW'(basis_reg);
        end
    end
    assign nlast = BW'(neff - NW'(1));

    assign mat_ok  = (32'(in_ia) < MAX_BASIS) && (32'(in_ib) < MAX_BASIS);
    assign int_ok  = (32'(in_ia) < NP) && (32'(in_ib) < NP);
    assign ld_addr = DW'(in_ia[BW-1:0]) * DW'(MAX_BASIS) + DW'(in_ib[BW-1:0]);
    assign ld_iab  = IW'(in_ia) * IW'(NP) + IW'(in_ib);
    assign ld_iba  = IW'(in_ib) * IW'(NP) + IW'(in_ia);

    assign p_ab   = pair_of(a_reg, b_reg);
    assign p_mn   = pair_of(m_reg, n_reg);
    assign p_an   = pair_of(a_reg, n_reg);
    assign p_mb   = pair_of(m_reg, b_reg);
    assign j_addr = IW'(p_ab) * IW'(NP) + IW'(p_mn);
    assign k_addr = IW'(p_an) * IW'(NP) + IW'(p_mb);
    assign h_addr = DW'(m_reg) * DW'(MAX_BASIS) + DW'(n_reg);
    assign d_addr = DW'(a_reg) * DW'(MAX_BASIS) + DW'(b_reg);

    assign core_we    = s_acc && (in_mode == MODE_CORE) && mat_ok;
    assign da_we      = s_acc && (in_mode == MODE_DALPHA) && mat_ok;
    assign db_we      = s_acc && (in_mode == MODE_DBETA) && mat_ok;
    assign dens_raddr = d_addr;
    assign int_raddr  = (state_reg == ST_RDK) ? k_addr : j_addr;

    always_comb begin
        int_we    = 1'b0;
        int_waddr = ld_iab;
        int_wdata = in_val;
        if (state_reg == ST_CLEAR) begin
            int_we    = 1'b1;
            int_waddr = clr_reg;
            int_wdata = '0;
        end else if (state_reg == ST_INT2) begin
            int_we    = 1'b1;
            int_waddr = i2a_reg;
            int_wdata = i2d_reg;
        end else if (s_acc && (in_mode == MODE_INT) && int_ok) begin
            int_we = 1'b1;
        end
    end

    fmb_ram #(.WIDTH(64), .DEPTH(MAX_BASIS * MAX_BASIS)) u_core (
        .aclk(aclk), .we(core_we), .waddr(ld_addr), .wdata(in_val),
        .raddr(h_addr), .rdata(core_q)
    );
    fmb_ram #(.WIDTH(64), .DEPTH(MAX_BASIS * MAX_BASIS)) u_dalpha (
        .aclk(aclk), .we(da_we), .waddr(ld_addr), .wdata(in_val),
        .raddr(dens_raddr), .rdata(da_q)
    );
    fmb_ram #(.WIDTH(64), .DEPTH(MAX_BASIS * MAX_BASIS)) u_dbeta (
        .aclk(aclk), .we(db_we), .waddr(ld_addr), .wdata(in_val),
        .raddr(dens_raddr), .rdata(db_q)
    );
    fmb_ram #(.WIDTH(64), .DEPTH(NP * NP)) u_eri (
        .aclk(aclk), .we(int_we), .waddr(int_waddr), .wdata(int_wdata),
        .raddr(int_raddr), .rdata(int_q)
    );

    assign dt = sat_add(da_reg, db_reg);

    always_comb begin
        mul_x = db_reg;
        mul_y = kv_reg;
        if (state_reg == ST_DT) begin
            mul_x = spin_reg ? dt : da_reg;
            mul_y = jv_reg;
        end else if (state_reg == ST_MJ) begin
            mul_x = da_reg;
        end
    end

    fmb_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .x(mul_x), .y(mul_y), .done(mul_done), .p(mul_p)
    );

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        basis_next = basis_reg;
        spin_next  = spin_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ov_next    = ov_reg;
        fa_next    = fa_reg;
        fb_next    = fb_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        jv_next    = jv_reg;
        kv_next    = kv_reg;
        pj_next    = pj_reg;
        pka_next   = pka_reg;
        pkb_next   = pkb_reg;
        i2a_next   = i2a_reg;
        i2d_next   = i2d_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        ofa_next   = ofa_reg;
        ofb_next   = ofb_reg;
        olast_next = olast_reg;
        mul_start  = 1'b0;

        if (cfg_wr) begin
            if (paddr[2] == REG_BASIS) begin
                basis_next = pwdata[5:0];
            end else begin
                spin_next = pwdata[0];
            end
        end
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(NP * NP - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (in_mode == MODE_INT && int_ok) begin
                        i2a_next   = ld_iba;
                        i2d_next   = in_val;
                        state_next = ST_INT2;
                    end else if (in_mode == MODE_COMPUTE && 32'(in_ia) < 32'(neff)) begin
                        m_next     = in_ia[BW-1:0];
                        n_next     = '0;
                        state_next = ST_COL;
                    end
                end
            end
            ST_INT2: state_next = ST_IDLE;
            ST_COL: begin
                a_next     = '0;
                b_next     = '0;
                state_next = ST_COLW;
            end
            ST_COLW: begin
                fa_next    = core_q;
                fb_next    = core_q;
                state_next = ST_RDJ;
            end
            ST_RDJ: state_next = ST_RDK;
            ST_RDK: begin
                jv_next    = int_q;
                da_next    = da_q;
                db_next    = db_q;
                state_next = ST_DT;
            end
            ST_DT: begin
                kv_next    = int_q;
                mul_start  = 1'b1;
                state_next = ST_MJ;
            end
            ST_MJ: begin
                if (mul_done) begin
                    pj_next    = mul_p;
                    mul_start  = 1'b1;
                    state_next = ST_MKA;
                end
            end
            ST_MKA: begin
                if (mul_done) begin
                    pka_next = mul_p;
                    if (spin_reg) begin
                        mul_start  = 1'b1;
                        state_next = ST_MKB;
                    end else begin
                        state_next = ST_ACC1;
                    end
                end
            end
            ST_MKB: begin
                if (mul_done) begin
                    pkb_next   = mul_p;
                    state_next = ST_ACC1;
                end
            end
            ST_ACC1: begin
                fa_next    = sat_add(fa_reg, pj_reg);
                fb_next    = sat_add(fb_reg, pj_reg);
                state_next = ST_ACC2;
            end
            ST_ACC2: begin
                if (spin_reg) begin
                    fa_next = sat_sub(fa_reg, pka_reg);
                    fb_next = sat_sub(fb_reg, pkb_reg);
                end else begin
                    fa_next = sat_add(fa_reg, pj_reg);
                end
                state_next = spin_reg ? ST_ACC3 : ST_ACC3;
            end
            ST_ACC3: begin
                if (!spin_reg) begin
                    fa_next = sat_sub(fa_reg, pka_reg);
                end
                if (b_reg != nlast) begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_RDJ;
                end else if (a_reg != nlast) begin
                    b_next     = '0;
                    a_next     = a_reg + 1'b1;
                    state_next = ST_RDJ;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!ov_reg || m_tready) begin
                    ov_next    = 1'b1;
                    orow_next  = 5'(m_reg);
                    ocol_next  = 5'(n_reg);
                    ofa_next   = fa_reg;
                    ofb_next   = spin_reg ? fb_reg : fa_reg;
                    olast_next = (n_reg == nlast);
                    if (n_reg == nlast) begin
                        state_next = ST_IDLE;
                    end else begin
                        n_next     = n_reg + 1'b1;
                        state_next = ST_COL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            basis_reg <= 6'd1;
            spin_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            m_reg     <= '0;
            n_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            basis_reg <= basis_next;
            spin_reg  <= spin_next;
            ov_reg    <= ov_next;
            m_reg     <= m_next;
            n_reg     <= n_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
        end
    end

    always_ff @(posedge aclk) begin
        fa_reg    <= fa_next;
        fb_reg    <= fb_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
        jv_reg    <= jv_next;
        kv_reg    <= kv_next;
        pj_reg    <= pj_next;
        pka_reg   <= pka_next;
        pkb_reg   <= pkb_next;
        i2a_reg   <= i2a_next;
        i2d_reg   <= i2d_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        ofa_reg   <= ofa_next;
        ofb_reg   <= ofb_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'b0, ofb_reg, ofa_reg, ocol_reg, orow_reg};
    assign m_tlast  = olast_reg;

endmodule

FILE: sim/fock_matrix_build_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fock_matrix_build_unit_test
// Drives load and compute-row transactions into the Fock matrix build unit
// under several basis sizes and both spin modes. A scoreboard keeps its own
// copy of the core, density and integral stores, predicts every Fock column
// and checks each result transaction in order, with random source gaps and
// sink stalls.
// ----------------------------------------------------------------------------
import fmb_pkg::*;

typedef struct {
    logic [4:0] row;
    logic [4:0] col;
    fx_t        fa;
    fx_t        fb;
    logic       last;
} fock_elem_t;

class fock_scoreboard;
    localparam int MAXB  = 32;
    localparam int NPAIR = MAXB * (MAXB + 1) / 2;
    localparam int FRAC  = 40;

    fx_t        core[MAXB*MAXB];
    fx_t        dens_a[MAXB*MAXB];
    fx_t        dens_b[MAXB*MAXB];
    bit         core_w[MAXB*MAXB];
    bit         da_w[MAXB*MAXB];
    bit         db_w[MAXB*MAXB];
    fx_t        eri[int];
    logic [5:0] basis;
    logic       spin;
    fock_elem_t fock_q[$];
    int         errors;
    int         checked;

    function new();
        basis = 1;
        spin = 0;
    endfunction

    function int n_eff();
        return (basis < 1) ? 1 : (basis > MAXB) ? MAXB : int'(basis);
    endfunction

    function int pair_idx(int x, int y);
        int h, l;
        h = (x > y) ? x : y;
        l = (x > y) ? y : x;
        return h * (h + 1) / 2 + l;
    endfunction

    function fx_t eri_at(int p, int q);
        int k;
        k = p * NPAIR + q;
        return eri.exists(k) ? eri[k] : fx_t'(0);
    endfunction

    function fx_t add_sat(fx_t a, fx_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
        return s[63:0];
    endfunction

    function fx_t sub_sat(fx_t a, fx_t b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
        return s[63:0];
    endfunction

    function fx_t fx_product(fx_t x, fx_t y);
        logic signed [127:0] p;
        logic signed [127:0] r;
        p = $signed({{64{x[63]}}, x}) * $signed({{64{y[63]}}, y});
        p = p + (128'sd1 <<< (FRAC - 1));
        r = p >>> FRAC;
        if (r[127:63] != {65{r[63]}}) return r[127] ? FX_MIN : FX_MAX;
        return r[63:0];
    endfunction

    function void write_reg(logic idx, logic [31:0] v);
        if (idx == REG_BASIS) basis = v[5:0];
        else spin = v[0];
    endfunction

    function void note_item(logic [2:0] md, logic [9:0] ia, logic [9:0] ib, fx_t v);
        int n, m, a, b, k;
        fx_t fa, fb, jv, kv, da, db, pj;
        fock_elem_t e;
        if (md == MODE_CORE || md == MODE_DALPHA || md == MODE_DBETA) begin
            if (ia < MAXB && ib < MAXB) begin
                k = ia * MAXB + ib;
                if (md == MODE_CORE) begin
                    core[k] = v;
                    core_w[k] = 1;
                end else if (md == MODE_DALPHA) begin
                    dens_a[k] = v;
                    da_w[k] = 1;
                end else begin
                    dens_b[k] = v;
                    db_w[k] = 1;
                end
            end
        end else if (md == MODE_INT) begin
            if (ia < NPAIR && ib < NPAIR) begin
                eri[ia * NPAIR + ib] = v;
                eri[ib * NPAIR + ia] = v;
            end
        end else if (md == MODE_COMPUTE && ia < n_eff()) begin
            m = ia;
            for (n = 0; n < n_eff(); n++) begin
                fa = core[m*MAXB + n];
                fb = fa;
                for (a = 0; a < n_eff(); a++) begin
                    for (b = 0; b < n_eff(); b++) begin
                        jv = eri_at(pair_idx(a, b), pair_idx(m, n));
                        kv = eri_at(pair_idx(a, n), pair_idx(m, b));
                        da = dens_a[a*MAXB + b];
                        if (!spin) begin
                            pj = fx_product(da, jv);
                            fa = add_sat(fa, pj);
                            fa = add_sat(fa, pj);
                            fa = sub_sat(fa, fx_product(da, kv));
                        end else begin
                            db = dens_b[a*MAXB + b];
                            pj = fx_product(add_sat(da, db), jv);
                            fa = add_sat(fa, pj);
                            fa = sub_sat(fa, fx_product(da, kv));
                            fb = add_sat(fb, pj);
                            fb = sub_sat(fb, fx_product(db, kv));
                        end
                    end
                end
                if (!spin) fb = fa;
                e.row = m[4:0];
                e.col = n[4:0];
                e.fa = fa;
                e.fb = fb;
                e.last = (n == n_eff() - 1);
                fock_q.push_back(e);
            end
        end
    endfunction

    task report(string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    task check(fock_elem_t got);
        fock_elem_t e;
        if (fock_q.size() == 0) begin
            report("result transaction with nothing pending");
            return;
        end
        e = fock_q.pop_front();
        checked++;
        if (got.row != e.row || got.col != e.col || got.fa != e.fa || got.fb != e.fb
            || got.last != e.last)
            report($sformatf("r%0d c%0d a=%h b=%h l=%0b, want r%0d c%0d a=%h b=%h l=%0b",
                got.row, got.col, got.fa, got.fb, got.last,
                e.row, e.col, e.fa, e.fb, e.last));
    endtask
endclass

module fock_matrix_build_unit_test;
    logic         aclk = 0;
    logic         aresetn;
    logic         psel, penable, pwrite, pready;
    logic [2:0]   paddr;
    logic [31:0]  pwdata, prdata;
    logic         s_tvalid, s_tready;
    logic [87:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid, m_tready, m_tlast;
    logic [143:0] m_tdata;

    fock_scoreboard sb = new();
    int burst_left = 0;
    int items_sent = 0;
    int stall_len = 0;

    fock_matrix_build_unit u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #60ms;
        $display("Verification failed");
        $finish;
    end

    // sink: random stalls in runs, with long stretches of always-ready
    always @(posedge aclk) begin
        if (stall_len > 0) begin
            stall_len <= stall_len - 1;
            m_tready <= 0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_len <= $urandom_range(1, 8);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        fock_elem_t g;
        if (aresetn && m_tvalid && m_tready) begin
            g.row = m_tdata[4:0];
            g.col = m_tdata[9:5];
            g.fa = m_tdata[73:10];
            g.fb = m_tdata[137:74];
            g.last = m_tlast;
            sb.check(g);
        end
    end

    function automatic fx_t rnd_val();
        case ($urandom_range(0, 5))
            0: return FX_MAX;
            1: return FX_MIN;
            2: return {$urandom, $urandom};
            default: return $signed({{24{1'b0}}, $urandom, 8'h0}) - (64'sd1 <<< 39);
        endcase
    endfunction

    task automatic send(logic [2:0] md, logic [9:0] ia, logic [9:0] ib, fx_t v);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1;
        s_tuser <= md;
        s_tdata <= {4'b0, v, ib, ia};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(md, ia, ib, v);
        items_sent++;
        burst_left--;
        if (burst_left == 0) s_tvalid <= 0;
    endtask

    task automatic wait_idle();
        if (burst_left != 0) s_tvalid <= 0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.fock_q.size() != 0 || !s_tready) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        sb.write_reg(idx, v);
        psel <= 0;
        penable <= 0;
        @(posedge aclk);
    endtask

    // fill the core and density entries a compute of row m will read that are still unwritten
    task automatic prepare_row(int m);
        int n, a, b;
        for (n = 0; n < sb.n_eff(); n++)
            if (!sb.core_w[m*32 + n]) send(MODE_CORE, m, n, rnd_val());
        for (a = 0; a < sb.n_eff(); a++)
            for (b = 0; b < sb.n_eff(); b++) begin
                if (!sb.da_w[a*32 + b]) send(MODE_DALPHA, a, b, rnd_val());
                if (sb.spin && !sb.db_w[a*32 + b]) send(MODE_DBETA, a, b, rnd_val());
            end
    endtask

    task automatic compute_row(int m);
        if (m < sb.n_eff()) prepare_row(m);
        send(MODE_COMPUTE, m, $urandom_range(0, 1023), {$urandom, $urandom});
    endtask

    task automatic random_items(int count);
        int i, p, r;
        logic [2:0] md;
        p = sb.n_eff() * (sb.n_eff() + 1) / 2;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send(MODE_INT, $urandom_range(0, p - 1), $urandom_range(0, p - 1), rnd_val());
            else if (r < 6) begin
                md = $urandom_range(0, 2);
                md = (md == 1) ? MODE_CORE : (md == 0) ? MODE_DALPHA : MODE_DBETA;
                send(md, $urandom_range(0, sb.n_eff() - 1), $urandom_range(0, sb.n_eff() - 1),
                     rnd_val());
            end else if (r < 8)
                compute_row($urandom_range(0, sb.n_eff() - 1));
            else begin
                md = $urandom_range(0, 7);
                if (md == MODE_COMPUTE) md = 3'd5 + $urandom_range(0, 2);
                send(md, $urandom_range(0, 1023), $urandom_range(0, 1023), {$urandom, $urandom});
            end
        end
    endtask

    initial begin
        int i;
        aresetn = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed, basis 1 restricted from reset
        send(MODE_CORE, 0, 0, FX_MAX);
        send(MODE_DALPHA, 0, 0, FX_MAX);
        send(MODE_INT, 0, 0, FX_MAX);
        send(MODE_COMPUTE, 0, 10'h3FF, 0);
        send(MODE_CORE, 0, 0, FX_MIN);
        send(MODE_DALPHA, 0, 0, FX_MIN);
        send(MODE_COMPUTE, 0, 0, 0);
        send(MODE_CORE, 32, 0, 64'sd5);
        send(MODE_DALPHA, 0, 10'h3FF, 64'sd5);
        send(MODE_DBETA, 10'h3FF, 10'h3FF, FX_MIN);
        send(MODE_INT, 528, 0, FX_MAX);
        send(MODE_INT, 0, 10'h3FF, FX_MAX);
        send(MODE_INT, 527, 527, 64'sh55AA_55AA_55AA_55AA);
        send(MODE_INT, 10'h155, 10'h2AA, FX_MIN);
        send(3'd5, 0, 0, FX_MAX);
        send(3'd6, 0, 0, FX_MAX);
        send(3'd7, 10'h3FF, 10'h3FF, FX_MIN);
        send(MODE_COMPUTE, 1, 0, 0);
        send(MODE_COMPUTE, 10'h3FF, 0, 0);
        send(MODE_INT, 0, 0, 64'sd1 <<< 40);
        send(MODE_DBETA, 0, 0, 64'sd3 <<< 39);
        wait_idle();
        apb_write(REG_SPIN, 32'hFFFF_FFFF);
        compute_row(0);
        wait_idle();
        apb_write(REG_BASIS, 32'hFFFF_FFC0);
        compute_row(0);

        // random phases across sizes and spin modes
        for (i = 0; i < 6; i++) begin
            wait_idle();
            apb_write(REG_BASIS, {$urandom} & 32'hFFFF_FFC0 | (2 + i % 4));
            apb_write(REG_SPIN, {$urandom} & 32'hFFFF_FFFE | (i % 2));
            random_items(8);
        end

        // widest clamped size: out-of-range row only
        wait_idle();
        apb_write(REG_BASIS, 32'd63);
        send(MODE_COMPUTE, 32, 0, 0);
        send(MODE_COMPUTE, 10'h3FF, 0, 0);

        wait_idle();
        repeat (100) @(posedge aclk);
        $display("%0d input transactions sent, %0d Fock elements checked, sizes 1 to 5",
                 items_sent, sb.checked);
        $display("restricted and unrestricted, clamped size, saturation and ignored items");
        if (sb.errors == 0 && sb.fock_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/fmb_pkg.sv
rtl/core/fmb_ram.sv
rtl/core/fmb_fxmul.sv
rtl/core/fock_matrix_build_unit.sv
sim/fock_matrix_build_unit_test.sv
